// File: hdl/ssd_pkg.sv
// ----------------------------------------------------------------------------
// ssd_pkg
// Shared types, segment constants and the character-to-segment lookup for
// the seven-segment scan driver.
// ----------------------------------------------------------------------------
package ssd_pkg;

    localparam int unsigned CODE_W  = 8;
    localparam int unsigned ROW_F_W = 2;
    localparam int unsigned COL_F_W = 3;
    localparam int unsigned POS_W   = 3;
    localparam int unsigned SEL_W   = 6;
    localparam int unsigned SEG_W   = 8;

    // item kinds carried in s_tuser
    localparam logic KIND_WRITE = 1'b0;
    localparam logic KIND_TICK  = 1'b1;

    localparam logic [SEG_W-1:0] SEG_BLANK      = 8'hFF;
    localparam logic [SEG_W-1:0] SEG_POINT_MASK = 8'h7F;

    localparam logic [SEG_W-1:0] DIGIT_SEGS [10] = '{
        8'hC0, 8'hF9, 8'hA4, 8'hB0, 8'h99, 8'h92, 8'h82, 8'hF8, 8'h80, 8'h90
    };

    // one store write, handed from the input stage to the character store
    typedef struct packed {
        logic               en;
        logic [ROW_F_W-1:0] row;
        logic [COL_F_W-1:0] column;
        logic [CODE_W-1:0]  code;
    } ssd_wr_t;

    // result word, first field in the highest bits
    typedef struct packed {
        logic [SEG_W-1:0] segments_row_zero;
        logic [SEG_W-1:0] segments_row_one;
        logic [SEG_W-1:0] segments_row_two;
        logic [SEL_W-1:0] digit_select;
    } ssd_result_t;

    // active-low segments, bit 7 is the point; unmapped codes are blank
    function automatic logic [SEG_W-1:0] ssd_glyph(input logic [CODE_W-1:0] c);
        logic [SEG_W-1:0] seg;
        seg = SEG_BLANK;
        case (c)
            8'h30, 8'h31, 8'h32, 8'h33, 8'h34,
            8'h35, 8'h36, 8'h37, 8'h38, 8'h39: seg = DIGIT_SEGS[4'(c - 8'h30)];
            8'h4C: seg = 8'hC7; // L
            8'h2E: seg = 8'h7F; // .
            8'h54: seg = 8'hF8; // T
            8'h4F: seg = 8'hC0; // O
            8'h41: seg = 8'h88; // A
            8'h53: seg = 8'h92; // S
            8'h48: seg = 8'h89; // H
            8'h49: seg = 8'hCF; // I
            8'h46: seg = 8'h8E; // F
            8'h47: seg = 8'hBC; // G
            8'h50: seg = 8'h8C; // P
            8'h43: seg = 8'hB1; // C
            8'h45: seg = 8'h86; // E
            8'h55: seg = 8'hC1; // U
            8'h4E: seg = 8'hC8; // N
            default: seg = SEG_BLANK;
        endcase
        return seg;
    endfunction

endpackage

// File: hdl/ssd_char_store.sv
// ----------------------------------------------------------------------------
// ssd_char_store
// Character codes for every row and column; reads one column of all rows.
// ----------------------------------------------------------------------------
module ssd_char_store #(
    parameter int unsigned ROWS   = 3,
    parameter int unsigned DIGITS = 6
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  ssd_pkg::ssd_wr_t                   wr,
    input  logic [ssd_pkg::POS_W-1:0]          rd_column,
    output logic [ROWS-1:0][ssd_pkg::CODE_W-1:0] rd_codes
);
    import ssd_pkg::*;

    localparam int unsigned ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int unsigned COL_W = (DIGITS > 1) ? $clog2(DIGITS) : 1;

    logic [CODE_W-1:0] store_reg [ROWS][DIGITS];
    logic              wr_hit;
    logic [ROW_W-1:0]  wr_row;
    logic [COL_W-1:0]  wr_col;
    logic [COL_W-1:0]  rd_col;

    // drop writes outside the built array
    assign wr_hit = wr.en && (wr.row < ROWS) && (wr.column < DIGITS);
    assign wr_row = ROW_W'(wr.row);
    assign wr_col = COL_W'(wr.column);
    assign rd_col = COL_W'(rd_column);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int r = 0; r < ROWS; r++) begin
                for (int d = 0; d < DIGITS; d++) begin
                    store_reg[r][d] <= '0;
                end
            end
        end else if (wr_hit) begin
            store_reg[wr_row][wr_col] <= wr.code;
        end
    end

    always_comb begin
        for (int r = 0; r < ROWS; r++) begin
            rd_codes[r] = store_reg[r][rd_col];
        end
    end

endmodule

// File: hdl/ssd_seg_mux.sv
// ----------------------------------------------------------------------------
// ssd_seg_mux
// Builds one result word: digit select, the three segment bytes and the
// row-one decimal point.
// ----------------------------------------------------------------------------
module ssd_seg_mux #(
    parameter int unsigned ROWS   = 3,
    parameter int unsigned DIGITS = 6
) (
    input  logic [ROWS-1:0][ssd_pkg::CODE_W-1:0] codes,
    input  logic [ssd_pkg::POS_W-1:0]            pos,
    input  logic [ssd_pkg::POS_W-1:0]            point_pos,
    output ssd_pkg::ssd_result_t                 result
);
    import ssd_pkg::*;

    logic [2:0][SEG_W-1:0] row_seg;
    logic [7:0]            sel_full;

    genvar gr;
    generate
        for (gr = 0; gr < 3; gr++) begin : g_row
            if (gr < ROWS) begin : g_built
                assign row_seg[gr] = ssd_glyph(codes[gr]);
            end else begin : g_missing
                assign row_seg[gr] = SEG_BLANK;
            end
        end
    endgenerate

    // scan 0 drives the leftmost column
    assign sel_full = 8'd1 << (POS_W'(DIGITS - 1) - pos);

    always_comb begin
        result.digit_select      = sel_full[SEL_W-1:0];
        result.segments_row_two  = row_seg[2];
        result.segments_row_one  = (point_pos == pos) ? (row_seg[1] & SEG_POINT_MASK)
                                                      : row_seg[1];
        result.segments_row_zero = row_seg[0];
    end

endmodule

// File: hdl/seven_segment_scan_driver_top.sv
// ----------------------------------------------------------------------------
// seven_segment_scan_driver_top
// Multiplexed driver for rows of seven-segment digits: write items fill the
// character store, tick items scan out one column per item.
// ----------------------------------------------------------------------------
//  channel  | direction | content
//  ---------+-----------+------------------------------------------------------
//  s_       | in        | tuser: kind; tdata: row, column, char_code
//  m_       | out       | tdata: digit_select, segments rows two, one, zero
//  cfg_     | in        | point_position, always ready
//
//  One item per cycle while s_tready is high. A tick item passes through the
//  input register; the lookup runs from there into the output register, where
//  the tick result becomes visible. Writes produce no result.
//  Reset clears the store to blank, the scan position to 0 and the point
//  position to 7. While m_tready is low a held result stays in the output
//  register and the input register takes items until it holds a tick; that tick stalls s_tready.
// ----------------------------------------------------------------------------
module seven_segment_scan_driver_top #(
    parameter int unsigned ROWS   = 3,
    parameter int unsigned DIGITS = 6
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // row[1:0], column[4:2], char_code[12:5]
    input  logic        s_tuser,   // kind
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // digit_select[5:0], segments_row_two[13:6],
                                   // segments_row_one[21:14], segments_row_zero[29:22]
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_data   // point_position
);
    import ssd_pkg::*;

    logic                st_valid_reg, st_valid_next;
    logic                st_kind_reg;
    logic [ROW_F_W-1:0]  st_row_reg;
    logic [COL_F_W-1:0]  st_col_reg;
    logic [CODE_W-1:0]   st_code_reg;
    logic                st_adv;
    logic                s_accept;
    logic                tick;

    logic [POS_W-1:0]    scan_pos_reg, scan_pos_next;
    logic [POS_W-1:0]    pos_eff;
    logic [POS_W-1:0]    point_pos_reg;

    logic                out_valid_reg, out_valid_next;
    ssd_result_t         out_reg;
    ssd_result_t         result;

    ssd_wr_t                       wr;
    logic [ROWS-1:0][CODE_W-1:0]   rd_codes;

    assign s_accept = s_tvalid && s_tready;
    // a tick may leave the input register only into a free output register
    assign st_adv   = st_valid_reg &&
                      ((st_kind_reg == KIND_WRITE) || !out_valid_reg || m_tready);
    assign s_tready = !st_valid_reg || st_adv;
    assign tick     = st_adv && (st_kind_reg == KIND_TICK);

    assign st_valid_next = s_accept ? 1'b1 : (st_adv ? 1'b0 : st_valid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_valid_reg <= 1'b0;
        end else begin
            st_valid_reg <= st_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            st_kind_reg <= s_tuser;
            st_row_reg  <= s_tdata[1:0];
            st_col_reg  <= s_tdata[4:2];
            st_code_reg <= s_tdata[12:5];
        end
    end

    // configuration
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            point_pos_reg <= 3'd7;
        end else if (cfg_valid && cfg_ready) begin
            point_pos_reg <= cfg_data;
        end
    end

    // scan position, wraps at DIGITS
    assign pos_eff       = (scan_pos_reg >= DIGITS) ? '0 : scan_pos_reg;
    assign scan_pos_next = !tick ? scan_pos_reg
                         : ((pos_eff >= POS_W'(DIGITS - 1)) ? '0 : pos_eff + 1'b1);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scan_pos_reg <= '0;
        end else begin
            scan_pos_reg <= scan_pos_next;
        end
    end

    always_comb begin
        wr.en     = st_valid_reg && (st_kind_reg == KIND_WRITE);
        wr.row    = st_row_reg;
        wr.column = st_col_reg;
        wr.code   = st_code_reg;
    end

    ssd_char_store #(
        .ROWS   (ROWS),
        .DIGITS (DIGITS)
    ) u_store (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .wr        (wr),
        .rd_column (pos_eff),
        .rd_codes  (rd_codes)
    );

    ssd_seg_mux #(
        .ROWS   (ROWS),
        .DIGITS (DIGITS)
    ) u_seg_mux (
        .codes     (rd_codes),
        .pos       (pos_eff),
        .point_pos (point_pos_reg),
        .result    (result)
    );

    // output register
    assign out_valid_next = tick ? 1'b1 : (m_tready ? 1'b0 : out_valid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (tick) begin
            out_reg <= result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b00, out_reg};

    // input side stalls only behind a held result
    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (m_tvalid && !m_tready))
        else $error("input stalled without a held result");

    a_scan_range: assert property (@(posedge aclk) disable iff (!aresetn)
        scan_pos_reg < DIGITS)
        else $error("scan position out of range");

    a_select_onehot: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (DIGITS <= SEL_W)) |-> $onehot(m_tdata[5:0]))
        else $error("digit select not one-hot");

    a_scan_advance: assert property (@(posedge aclk) disable iff (!aresetn)
        !tick |=> $stable(scan_pos_reg))
        else $error("scan position moved without a tick");

endmodule

// File: sim/tb_seven_segment_scan_driver_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_seven_segment_scan_driver_top
// Self-checking bench for the seven-segment scan driver. Write items fill a
// shadow character store, and tick items predict the digit select and the
// three segment bytes of the scanned column. The bench covers reset contents,
// the character table, writes outside the store, point positions 0 and 3 to 7,
// random traffic with idle gaps, a long output stall and a full-rate stretch.
// ----------------------------------------------------------------------------
module tb_seven_segment_scan_driver_top;
    import ssd_pkg::*;

    localparam int ROWS      = 3;
    localparam int DIGITS    = 6;
    localparam int LONG_HOLD = 50;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [15:0] s_tdata;   // row[1:0], column[4:2], char_code[12:5]
    logic        s_tuser;   // kind
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;   // digit_select[5:0], row two[13:6], row one[21:14], row zero[29:22]
    logic        cfg_valid;
    logic        cfg_ready;
    logic [2:0]  cfg_data;  // point_position

    // shadow of the display
    logic [7:0]  display_chars [ROWS*DIGITS];
    int          scan_col;
    logic [2:0]  point_col;
    ssd_result_t scan_results_q [$];

    int          err_count;
    bit          src_idle_on;
    bit          sink_idle_on;
    bit          long_hold_req;
    string       glyph_chars = "0123456789LTOASHIFGPCEUN.";

    seven_segment_scan_driver_top u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #2_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    function automatic logic [7:0] seg_for_code(input logic [7:0] c);
        case (c)
            "0": return 8'hC0;
            "1": return 8'hF9;
            "2": return 8'hA4;
            "3": return 8'hB0;
            "4": return 8'h99;
            "5": return 8'h92;
            "6": return 8'h82;
            "7": return 8'hF8;
            "8": return 8'h80;
            "9": return 8'h90;
            "L": return 8'hC7;
            ".": return 8'h7F;
            "T": return 8'hF8;
            "O": return 8'hC0;
            "A": return 8'h88;
            "S": return 8'h92;
            "H": return 8'h89;
            "I": return 8'hCF;
            "F": return 8'h8E;
            "G": return 8'hBC;
            "P": return 8'h8C;
            "C": return 8'hB1;
            "E": return 8'h86;
            "U": return 8'hC1;
            "N": return 8'hC8;
            default: return SEG_BLANK;
        endcase
    endfunction

    // apply one accepted item to the shadow display
    task automatic apply_display_item(input logic kind, input logic [1:0] row,
                                      input logic [2:0] col, input logic [7:0] code);
        ssd_result_t r;
        int          pos;
        if (kind == KIND_WRITE) begin
            if (int'(row) < ROWS && int'(col) < DIGITS)
                display_chars[int'(row) * DIGITS + int'(col)] = code;
        end else begin
            pos = (scan_col >= DIGITS) ? 0 : scan_col;
            r.digit_select      = 6'(1 << (DIGITS - 1 - pos));
            r.segments_row_two  = seg_for_code(display_chars[2 * DIGITS + pos]);
            r.segments_row_one  = seg_for_code(display_chars[DIGITS + pos]);
            if (int'(point_col) == pos)
                r.segments_row_one = r.segments_row_one & SEG_POINT_MASK;
            r.segments_row_zero = seg_for_code(display_chars[pos]);
            scan_results_q.push_back(r);
            scan_col = (pos + 1 >= DIGITS) ? 0 : pos + 1;
        end
    endtask

    // offer one item and hold it until the handshake; tvalid stays high afterwards
    task automatic send_item(input logic kind, input logic [1:0] row,
                             input logic [2:0] col, input logic [7:0] code);
        if (src_idle_on && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {3'b000, code, col, row};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        apply_display_item(kind, row, col, code);
    endtask

    task automatic send_random_item(input int tick_pct);
        logic       kind;
        logic [1:0] row;
        logic [2:0] col;
        logic [7:0] code;
        kind = ($urandom_range(0, 99) < tick_pct) ? KIND_TICK : KIND_WRITE;
        if ($urandom_range(0, 7) == 0) begin
            row = 2'($urandom);
            col = 3'($urandom);
        end else begin
            row = 2'($urandom_range(0, ROWS - 1));
            col = 3'($urandom_range(0, DIGITS - 1));
        end
        if ($urandom_range(0, 2) == 0)
            code = 8'($urandom);
        else
            code = glyph_chars[$urandom_range(0, glyph_chars.len() - 1)];
        send_item(kind, row, col, code);
    endtask

    // drop tvalid and wait until every scan result is back and writes have settled
    task automatic wait_scan_drain();
        s_tvalid <= 1'b0;
        while (scan_results_q.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic set_point_column(input logic [2:0] v);
        wait_scan_drain();
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        point_col = v;
    endtask

    task automatic test_reset_blank();
        repeat (DIGITS) send_item(KIND_TICK, 2'd0, 3'd0, 8'h00);
    endtask

    task automatic test_write_corners();
        set_point_column(3'd0);
        send_item(KIND_WRITE, 2'd0, 3'd0, "8");
        send_item(KIND_WRITE, 2'd1, 3'd0, ".");
        send_item(KIND_WRITE, 2'd2, 3'd0, "N");
        send_item(KIND_WRITE, 2'd2, 3'd5, 8'hFF);
        send_item(KIND_WRITE, 2'd1, 3'd5, "E");
        send_item(KIND_WRITE, 2'd0, 3'd5, 8'h00);
        // outside the store: must leave it untouched
        send_item(KIND_WRITE, 2'd3, 3'd0, "1");
        send_item(KIND_WRITE, 2'd0, 3'd6, "2");
        send_item(KIND_WRITE, 2'd3, 3'd7, "3");
        // tick fields other than kind are don't-care
        repeat (DIGITS) send_item(KIND_TICK, 2'd3, 3'd7, 8'hFF);
    endtask

    task automatic test_random_phases();
        logic [2:0] points [6];
        points = '{3'd7, 3'd0, 3'd5, 3'd6, 3'd3, 3'($urandom)};
        for (int p = 0; p < 6; p++) begin
            set_point_column(points[p]);
            src_idle_on  = (p != 3);
            sink_idle_on = (p != 3);
            repeat (80) send_random_item(35);
        end
    endtask

    task automatic test_output_stall();
        set_point_column(3'($urandom));
        src_idle_on   = 1'b0;
        long_hold_req = 1'b1;
        repeat (30) send_random_item(70);
        src_idle_on   = 1'b1;
    endtask

    task automatic test_full_rate();
        set_point_column(3'd4);
        src_idle_on  = 1'b0;
        sink_idle_on = 1'b0;
        repeat (100) send_random_item(50);
    endtask

    // result consumer: random stalls plus one long hold on request
    initial begin
        m_tready <= 1'b1;
        forever begin
            @(posedge aclk);
            if (long_hold_req) begin
                m_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge aclk);
                long_hold_req = 1'b0;
                m_tready <= 1'b1;
            end else if (sink_idle_on && $urandom_range(0, 4) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 3)) @(posedge aclk);
                m_tready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        ssd_result_t got;
        ssd_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got = m_tdata[29:0];
            if (scan_results_q.size() == 0) begin
                $error("unexpected scan result %h", m_tdata);
                err_count++;
            end else begin
                want = scan_results_q.pop_front();
                if (got.digit_select !== want.digit_select) begin
                    $error("digit_select: expected %h, actual %h",
                           want.digit_select, got.digit_select);
                    err_count++;
                end
                if (got.segments_row_two !== want.segments_row_two) begin
                    $error("segments_row_two: expected %h, actual %h",
                           want.segments_row_two, got.segments_row_two);
                    err_count++;
                end
                if (got.segments_row_one !== want.segments_row_one) begin
                    $error("segments_row_one: expected %h, actual %h",
                           want.segments_row_one, got.segments_row_one);
                    err_count++;
                end
                if (got.segments_row_zero !== want.segments_row_zero) begin
                    $error("segments_row_zero: expected %h, actual %h",
                           want.segments_row_zero, got.segments_row_zero);
                    err_count++;
                end
            end
        end
    end

    initial begin
        err_count     = 0;
        src_idle_on   = 1'b1;
        sink_idle_on  = 1'b1;
        long_hold_req = 1'b0;
        foreach (display_chars[i]) display_chars[i] = 8'h00;
        scan_col  = 0;
        point_col = 3'd7;
        aresetn   <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tuser   <= KIND_WRITE;
        cfg_valid <= 1'b0;
        cfg_data  <= '0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_reset_blank();
        test_write_corners();
        test_random_phases();
        test_output_stall();
        test_full_rate();

        wait_scan_drain();
        repeat (10) @(posedge aclk);
        if (err_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
